/* rtl/dtoi_pkg.sv */
`timescale 1ns / 1ps
// dtoi_pkg: types and constants shared by the decimal text parser
// no dependencies; used by the interfaces and every rtl module

package dtoi_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;
    localparam int ACC_W   = 64;
    localparam int PROD_W  = ACC_W + 4;
    localparam int DIGIT_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE   = 1'b1;

    // largest magnitudes per mode
    localparam logic [ACC_W-1:0] LIM_U64     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] LIM_S64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] LIM_S64_NEG = 64'h8000_0000_0000_0000;
    localparam logic [ACC_W-1:0] LIM_U32     = 64'h0000_0000_FFFF_FFFF;
    localparam logic [ACC_W-1:0] LIM_S32_POS = 64'h0000_0000_7FFF_FFFF;
    localparam logic [ACC_W-1:0] LIM_S32_NEG = 64'h0000_0000_8000_0000;

    localparam logic [VALUE_W-1:0] LOW32_MASK = 64'h0000_0000_FFFF_FFFF;

    typedef enum logic [3:0] {
        PH_SPACE = 4'b0001,
        PH_DIGIT = 4'b0010,
        PH_STOP  = 4'b0100,
        PH_FAIL  = 4'b1000
    } phase_t;

    // parse state captured at the end of a string
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic             minus;
        logic             ok;
        logic             wide;
    } done_t;

endpackage

/* rtl/dtoi_char_if.sv */
`timescale 1ns / 1ps
// dtoi_char_if: valid/ready channel carrying one text character per transaction
// depends on dtoi_pkg

interface dtoi_char_if;
    logic                       valid;
    logic                       ready;
    logic [dtoi_pkg::CHAR_W-1:0] char_byte;
    logic                       has_char;
    logic                       end_of_string;

    modport source (output valid, output char_byte, output has_char,
                    output end_of_string, input ready);
    modport sink   (input valid, input char_byte, input has_char,
                    input end_of_string, output ready);
endinterface

/* rtl/dtoi_result_if.sv */
`timescale 1ns / 1ps
// dtoi_result_if: valid/ready channel carrying one parse result per transaction
// depends on dtoi_pkg

interface dtoi_result_if;
    logic                         valid;
    logic                         ready;
    logic [dtoi_pkg::VALUE_W-1:0] parsed_value;
    logic                         parse_ok;

    modport source (output valid, output parsed_value, output parse_ok, input ready);
    modport sink   (input valid, input parsed_value, input parse_ok, output ready);
endinterface

/* rtl/dtoi_cfg_if.sv */
`timescale 1ns / 1ps
// dtoi_cfg_if: configuration write channel, register index and write data
// depends on dtoi_pkg

interface dtoi_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dtoi_pkg::CFG_IDX_W-1:0]  index;
    logic [dtoi_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/dtoi_parse.sv */
`timescale 1ns / 1ps
// dtoi_parse: input register and per-character parse state update
// depends on dtoi_pkg and dtoi_char_if

module dtoi_parse
(
    input  logic                 clk,
    input  logic                 rst_n,
    dtoi_char_if.sink            char_in,
    input  logic                 signed_mode,
    input  logic                 wide_mode,
    output logic                 done_valid,
    input  logic                 done_ready,
    output dtoi_pkg::done_t      done
);

    // input register
    logic                          s1_valid_reg;
    logic [dtoi_pkg::CHAR_W-1:0]   s1_char_reg;
    logic                          s1_has_reg;
    logic                          s1_last_reg;

    // parse state
    dtoi_pkg::phase_t              phase_reg, phase_next;
    logic [dtoi_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic                          minus_reg, minus_next;
    logic                          saw_reg, saw_next;

    logic                          s1_adv;
    logic                          fire;
    logic                          is_ws;
    logic                          is_digit;
    logic [dtoi_pkg::DIGIT_W-1:0]  digit;
    logic [dtoi_pkg::ACC_W-1:0]    limit;
    logic [dtoi_pkg::PROD_W-1:0]   prod;
    logic                          overflow;

    assign s1_adv       = !s1_last_reg || done_ready;
    assign char_in.ready = !s1_valid_reg || s1_adv;
    assign fire         = s1_valid_reg && s1_adv;
    assign done_valid   = s1_valid_reg && s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (char_in.ready)
        begin
            s1_valid_reg <= char_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.ready && char_in.valid)
        begin
            s1_char_reg <= char_in.char_byte;
            s1_has_reg  <= char_in.has_char;
            s1_last_reg <= char_in.end_of_string;
        end
    end

    assign is_ws    = (s1_char_reg == dtoi_pkg::CH_SPACE) ||
                      ((s1_char_reg >= dtoi_pkg::CH_TAB) && (s1_char_reg <= dtoi_pkg::CH_CR));
    assign is_digit = (s1_char_reg >= dtoi_pkg::CH_ZERO) && (s1_char_reg <= dtoi_pkg::CH_NINE);
    assign digit    = s1_char_reg[dtoi_pkg::DIGIT_W-1:0];

    always_comb
    begin
        case ({wide_mode, signed_mode, minus_reg})
            3'b100, 3'b101: limit = dtoi_pkg::LIM_U64;
            3'b110:         limit = dtoi_pkg::LIM_S64_POS;
            3'b111:         limit = dtoi_pkg::LIM_S64_NEG;
            3'b000, 3'b001: limit = dtoi_pkg::LIM_U32;
            3'b010:         limit = dtoi_pkg::LIM_S32_POS;
            3'b011:         limit = dtoi_pkg::LIM_S32_NEG;
            default:        limit = dtoi_pkg::LIM_U64;
        endcase
    end

    // acc * 10 + digit, overflow when it passes the mode limit
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                + {{(dtoi_pkg::PROD_W-dtoi_pkg::DIGIT_W){1'b0}}, digit};
    assign overflow = prod > {4'b0, limit};

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        minus_next = minus_reg;
        saw_next   = saw_reg;
        if (s1_has_reg)
        begin
            saw_next = 1'b1;
            case (phase_reg)
                dtoi_pkg::PH_SPACE:
                begin
                    if (is_ws)
                    begin
                        phase_next = dtoi_pkg::PH_SPACE;
                    end
                    else if (s1_char_reg == dtoi_pkg::CH_MINUS)
                    begin
                        if (signed_mode)
                        begin
                            minus_next = 1'b1;
                            phase_next = dtoi_pkg::PH_DIGIT;
                        end
                        else
                        begin
                            phase_next = dtoi_pkg::PH_FAIL;
                        end
                    end
                    else if (s1_char_reg == dtoi_pkg::CH_PLUS)
                    begin
                        phase_next = dtoi_pkg::PH_DIGIT;
                    end
                    else if (is_digit)
                    begin
                        if (overflow)
                        begin
                            phase_next = dtoi_pkg::PH_FAIL;
                        end
                        else
                        begin
                            acc_next   = prod[dtoi_pkg::ACC_W-1:0];
                            phase_next = dtoi_pkg::PH_DIGIT;
                        end
                    end
                    else
                    begin
                        phase_next = dtoi_pkg::PH_STOP;
                    end
                end
                dtoi_pkg::PH_DIGIT:
                begin
                    if (!is_digit)
                    begin
                        phase_next = dtoi_pkg::PH_STOP;
                    end
                    else if (overflow)
                    begin
                        phase_next = dtoi_pkg::PH_FAIL;
                    end
                    else
                    begin
                        acc_next = prod[dtoi_pkg::ACC_W-1:0];
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // snapshot at end of string
    assign done.acc   = acc_next;
    assign done.minus = minus_next;
    assign done.ok    = saw_next && (phase_next != dtoi_pkg::PH_FAIL);
    assign done.wide  = wide_mode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dtoi_pkg::PH_SPACE;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            saw_reg   <= 1'b0;
        end
        else if (fire)
        begin
            if (s1_last_reg)
            begin
                phase_reg <= dtoi_pkg::PH_SPACE;
                acc_reg   <= '0;
                minus_reg <= 1'b0;
                saw_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                minus_reg <= minus_next;
                saw_reg   <= saw_next;
            end
        end
    end

endmodule

/* rtl/dtoi_result.sv */
`timescale 1ns / 1ps
// dtoi_result: end-of-string snapshot register, sign apply and output register
// depends on dtoi_pkg and dtoi_result_if

module dtoi_result
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 done_valid,
    output logic                 done_ready,
    input  dtoi_pkg::done_t      done,
    dtoi_result_if.source        result_out
);

    logic                          s2_valid_reg;
    dtoi_pkg::done_t               s2_reg;
    logic                          out_valid_reg;
    logic [dtoi_pkg::VALUE_W-1:0]  value_reg, value_next;
    logic                          ok_reg;
    logic                          s3_load;
    logic [dtoi_pkg::VALUE_W-1:0]  signed_val;

    assign s3_load    = !out_valid_reg || result_out.ready;
    assign done_ready = !s2_valid_reg || s3_load;

    assign signed_val = s2_reg.minus ? (~s2_reg.acc + 64'd1) : s2_reg.acc;

    always_comb
    begin
        if (!s2_reg.ok)
        begin
            value_next = '0;
        end
        else if (s2_reg.wide)
        begin
            value_next = signed_val;
        end
        else
        begin
            value_next = signed_val & dtoi_pkg::LOW32_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (done_ready)
            begin
                s2_valid_reg <= done_valid;
            end
            if (s3_load)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_ready && done_valid)
        begin
            s2_reg <= done;
        end
        if (s3_load && s2_valid_reg)
        begin
            value_reg <= value_next;
            ok_reg    <= s2_reg.ok;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.parsed_value = value_reg;
    assign result_out.parse_ok     = ok_reg;

endmodule

/* rtl/decimal_text_to_integer_top.sv */
`timescale 1ns / 1ps
// decimal_text_to_integer_top: parses a stream of ascii characters, one per
// transaction, as a decimal integer and returns one result per string.
// Leading whitespace (space, tab through carriage return) is skipped, one
// optional sign is taken, then digits accumulate; the first non-digit stops
// parsing and the rest of the string is ignored. The transaction marked
// end_of_string produces the result: the value (two's complement when signed,
// low 32 bits zero-extended in 32-bit mode, zero on failure) and parse_ok,
// which is low for an empty string, a minus in unsigned mode, or overflow.
// A character is taken every cycle unless an end-of-string character waits on
// a full result stage; results pass the input, snapshot and output registers.
// The rate is set by the per-character multiply-by-ten add and limit compare.
// Configuration (signed_mode at index 0, wide_mode at index 1) is written
// through the cfg channel and should only change while no string is open.
// depends on dtoi_pkg, dtoi_char_if, dtoi_result_if, dtoi_cfg_if,
// dtoi_parse and dtoi_result

module decimal_text_to_integer_top
(
    input  logic          clk,
    input  logic          rst_n,
    dtoi_char_if.sink     char_in,
    dtoi_result_if.source result_out,
    dtoi_cfg_if.sink      cfg
);

    // mode registers
    logic            signed_mode_reg;
    logic            wide_mode_reg;

    // end-of-string handoff between parser and result stage
    logic            done_valid;
    logic            done_ready;
    dtoi_pkg::done_t done;

    // config writes always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b0;
            wide_mode_reg   <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dtoi_pkg::CFG_SIGNED_MODE: signed_mode_reg <= cfg.data[0];
                dtoi_pkg::CFG_WIDE_MODE:   wide_mode_reg   <= cfg.data[0];
                default:                   signed_mode_reg <= signed_mode_reg;
            endcase
        end
    end

    // character register and parse state
    dtoi_parse u_parse
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_in     (char_in),
        .signed_mode (signed_mode_reg),
        .wide_mode   (wide_mode_reg),
        .done_valid  (done_valid),
        .done_ready  (done_ready),
        .done        (done)
    );

    // snapshot, sign apply and output register
    dtoi_result u_result
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .done       (done),
        .result_out (result_out)
    );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for decimal_text_to_integer_top, with random
// strings, random idling on both channels and a built-in parse predictor
// depends on dtoi_pkg, dtoi_char_if, dtoi_result_if, dtoi_cfg_if and the rtl

module testbench;

    // widths used in declarations and size casts
    localparam int CHAR_W  = dtoi_pkg::CHAR_W;
    localparam int VALUE_W = dtoi_pkg::VALUE_W;
    localparam int ACC_W   = dtoi_pkg::ACC_W;
    localparam int DIGIT_W = dtoi_pkg::DIGIT_W;

    // one character transaction as offered to the block
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              has;
        logic              last;
    } char_item_t;

    // one parse result, as predicted or as seen on the result channel
    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               ok;
    } parse_result_t;

    logic clk = 1'b0;
    logic rst_n;

    dtoi_char_if   char_ch ();
    dtoi_result_if res_ch ();
    dtoi_cfg_if    cfg_ch ();

    decimal_text_to_integer_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_ch),
        .result_out (res_ch),
        .cfg        (cfg_ch)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // stimulus and scoreboard storage
    char_item_t    pending_chars[$];
    parse_result_t expected_results[$];
    logic [CHAR_W-1:0] text_buf[$];
    int items_queued = 0;
    int error_count  = 0;

    // idling knobs, percent of cycles in which each side sits out
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // receiver hold-off, counted down by the receiver process
    int rx_stall_left = 0;

    // char transaction accepted at the last rising edge
    logic char_took = 1'b0;

    // predictor copy of the configuration and parse state
    logic             mode_signed;
    logic             mode_wide;
    dtoi_pkg::phase_t parse_ph;
    logic [ACC_W-1:0] acc_mag;
    logic             neg_sign;
    logic             got_char;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // largest magnitude the current modes allow, given the sign
    function automatic logic [ACC_W-1:0] magnitude_limit(input logic neg);
        if (mode_wide)
        begin
            if (!mode_signed)
                return dtoi_pkg::LIM_U64;
            return neg ? dtoi_pkg::LIM_S64_NEG : dtoi_pkg::LIM_S64_POS;
        end
        if (!mode_signed)
            return dtoi_pkg::LIM_U32;
        return neg ? dtoi_pkg::LIM_S32_NEG : dtoi_pkg::LIM_S32_POS;
    endfunction

    function automatic void clear_parse();
        parse_ph = dtoi_pkg::PH_SPACE;
        acc_mag  = '0;
        neg_sign = 1'b0;
        got_char = 1'b0;
    endfunction

    // value times ten plus digit, failing when the limit would be passed
    function automatic void take_digit(input logic [DIGIT_W-1:0] d);
        logic [ACC_W-1:0] lim;
        lim = magnitude_limit(neg_sign);
        if (acc_mag > (lim - ACC_W'(d)) / 10)
            parse_ph = dtoi_pkg::PH_FAIL;
        else
        begin
            acc_mag  = acc_mag * 10 + ACC_W'(d);
            parse_ph = dtoi_pkg::PH_DIGIT;
        end
    endfunction

    function automatic void parse_char(input logic [CHAR_W-1:0] c);
        logic is_digit;
        logic is_space;
        is_digit = (c >= dtoi_pkg::CH_ZERO) && (c <= dtoi_pkg::CH_NINE);
        is_space = (c == dtoi_pkg::CH_SPACE) ||
                   ((c >= dtoi_pkg::CH_TAB) && (c <= dtoi_pkg::CH_CR));
        case (parse_ph)
            dtoi_pkg::PH_SPACE:
            begin
                if (is_space)
                    return;
                if (c == dtoi_pkg::CH_MINUS)
                begin
                    if (mode_signed)
                    begin
                        neg_sign = 1'b1;
                        parse_ph = dtoi_pkg::PH_DIGIT;
                    end
                    else
                        parse_ph = dtoi_pkg::PH_FAIL;
                end
                else if (c == dtoi_pkg::CH_PLUS)
                    parse_ph = dtoi_pkg::PH_DIGIT;
                else if (is_digit)
                    take_digit(DIGIT_W'(c - dtoi_pkg::CH_ZERO));
                else
                    parse_ph = dtoi_pkg::PH_STOP;
            end
            dtoi_pkg::PH_DIGIT:
            begin
                if (is_digit)
                    take_digit(DIGIT_W'(c - dtoi_pkg::CH_ZERO));
                else
                    parse_ph = dtoi_pkg::PH_STOP;
            end
            default: ;
        endcase
    endfunction

    // one accepted char transaction; the end of a string yields a result
    function automatic void absorb_char(input char_item_t it);
        parse_result_t r;
        if (it.has)
        begin
            got_char = 1'b1;
            parse_char(it.ch);
        end
        if (!it.last)
            return;
        r.ok    = got_char && (parse_ph != dtoi_pkg::PH_FAIL);
        r.value = '0;
        if (r.ok)
        begin
            r.value = neg_sign ? -acc_mag : acc_mag;
            if (!mode_wide)
                r.value &= dtoi_pkg::LOW32_MASK;
        end
        expected_results.push_back(r);
        clear_parse();
    endfunction

    // ------------------------------------------------------------------
    // char driver: a transaction is held until taken, inputs move on the
    // falling edge only
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_chars
        char_item_t next_item;
        if (!rst_n)
            char_ch.valid <= 1'b0;
        else if (char_ch.valid && !char_took)
            ;   // still waiting for ready, keep the transaction on the bus
        else if (pending_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct)
        begin
            next_item = pending_chars.pop_front();
            char_ch.char_byte     <= next_item.ch;
            char_ch.has_char      <= next_item.has;
            char_ch.end_of_string <= next_item.last;
            char_ch.valid         <= 1'b1;
        end
        else
            char_ch.valid <= 1'b0;
    end

    // result receiver: random idling plus the long hold-off countdown
    always @(negedge clk)
    begin
        if (rx_stall_left > 0)
        begin
            rx_stall_left = rx_stall_left - 1;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // monitor: everything is sampled at the rising edge, before the block
    // updates its registers
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_channels
        char_item_t    seen;
        parse_result_t want;
        if (!rst_n)
            char_took = 1'b0;
        else
        begin
            // check results first so a string ending now never matches itself
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result value %h ok %b",
                                              res_ch.parsed_value, res_ch.parse_ok));
                else
                begin
                    want = expected_results.pop_front();
                    if (res_ch.parsed_value !== want.value)
                        report_mismatch($sformatf("parsed_value got %h want %h",
                                                  res_ch.parsed_value, want.value));
                    if (res_ch.parse_ok !== want.ok)
                        report_mismatch($sformatf("parse_ok got %b want %b",
                                                  res_ch.parse_ok, want.ok));
                end
            end
            // register writes go straight into the predictor's copy
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == dtoi_pkg::CFG_SIGNED_MODE)
                    mode_signed = cfg_ch.data[0];
                else if (cfg_ch.index == dtoi_pkg::CFG_WIDE_MODE)
                    mode_wide = cfg_ch.data[0];
            end
            char_took = char_ch.valid && char_ch.ready;
            if (char_took)
            begin
                seen.ch   = char_ch.char_byte;
                seen.has  = char_ch.has_char;
                seen.last = char_ch.end_of_string;
                absorb_char(seen);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [CHAR_W-1:0] c, input logic has, input logic last);
        char_item_t it;
        it.ch   = c;
        it.has  = has;
        it.last = last;
        pending_chars.push_back(it);
        items_queued++;
    endtask

    // turn the text buffer into char transactions, sprinkling in no-char
    // transactions that are not last; an empty buffer becomes an empty string
    task automatic commit_text(input logic marker_end);
        int i;
        for (i = 0; i < text_buf.size(); i++)
        begin
            if ($urandom_range(15) == 0)
                push_item(CHAR_W'($urandom_range(255)), 1'b0, 1'b0);
            push_item(text_buf[i], 1'b1, !marker_end && (i == text_buf.size() - 1));
        end
        if (marker_end || text_buf.size() == 0)
            push_item(CHAR_W'($urandom_range(255)), 1'b0, 1'b1);
        text_buf.delete();
    endtask

    task automatic push_text(input string s, input logic marker_end);
        int i;
        for (i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        commit_text(marker_end);
    endtask

    function automatic logic [CHAR_W-1:0] pick_space();
        if ($urandom_range(1) == 0)
            return dtoi_pkg::CH_SPACE;
        return dtoi_pkg::CH_TAB +
               CHAR_W'($urandom_range(dtoi_pkg::CH_CR - dtoi_pkg::CH_TAB));
    endfunction

    task automatic add_digits(input int count);
        repeat (count)
            text_buf.push_back(dtoi_pkg::CH_ZERO + CHAR_W'($urandom_range(9)));
    endtask

    // one random string: mostly well-formed numbers, some near the mode's
    // limit, plus noise, broken signs and empty strings
    task automatic push_random_string();
        int kind;
        int r;
        int i;
        logic [CHAR_W-1:0] sign;
        logic [ACC_W+5:0]  big;
        string             dec;
        kind = $urandom_range(99);
        if (kind < 65)
        begin
            repeat ($urandom_range(2))
                text_buf.push_back(pick_space());
            r = $urandom_range(9);
            sign = (r < 3) ? dtoi_pkg::CH_MINUS : (r < 5) ? dtoi_pkg::CH_PLUS : '0;
            if (sign != '0)
                text_buf.push_back(sign);
            if ($urandom_range(7) == 0)
                repeat ($urandom_range(1, 3))
                    text_buf.push_back(dtoi_pkg::CH_ZERO);
            r = $urandom_range(9);
            if (r < 4)
                add_digits($urandom_range(1, 6));
            else if (r < 7)
            begin
                // a few either side of the largest magnitude
                big = {6'd0, magnitude_limit((sign == dtoi_pkg::CH_MINUS) && mode_signed)};
                big = big + 3 - $urandom_range(6);
                dec = $sformatf("%0d", big);
                for (i = 0; i < dec.len(); i++)
                    text_buf.push_back(dec[i]);
            end
            else
                add_digits($urandom_range(8, 21));
            if ($urandom_range(9) < 3)
                repeat ($urandom_range(1, 3))
                    text_buf.push_back(CHAR_W'($urandom_range(255)));
            commit_text($urandom_range(4) == 0);
        end
        else if (kind < 80)
        begin
            repeat ($urandom_range(1, 6))
                text_buf.push_back(CHAR_W'($urandom_range(255)));
            commit_text($urandom_range(3) == 0);
        end
        else if (kind < 93)
        begin
            // a sign followed by something that is not a digit
            if ($urandom_range(1) == 0)
                text_buf.push_back(pick_space());
            text_buf.push_back($urandom_range(1) ? dtoi_pkg::CH_PLUS : dtoi_pkg::CH_MINUS);
            r = $urandom_range(2);
            text_buf.push_back((r == 0) ? dtoi_pkg::CH_PLUS :
                               (r == 1) ? dtoi_pkg::CH_MINUS : pick_space());
            add_digits($urandom_range(0, 3));
            commit_text($urandom_range(3) == 0);
        end
        else
            commit_text(1'b1);
    endtask

    // wait for the char queue and the expected results to drain, then let
    // the pipeline settle
    task automatic wait_drained();
        @(negedge clk);
        while (pending_chars.size() != 0 || char_ch.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [dtoi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dtoi_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        @(posedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // one configuration setting with random strings; optionally the sender
    // stops halfway until every result so far has come back
    task automatic run_phase(input logic sgn, input logic wide, input int budget,
                             input logic pause_midway);
        int start;
        write_reg(dtoi_pkg::CFG_SIGNED_MODE, sgn);
        write_reg(dtoi_pkg::CFG_WIDE_MODE, wide);
        start = items_queued;
        while (items_queued - start < budget)
        begin
            push_random_string();
            if (pause_midway && items_queued - start >= budget / 2)
            begin
                pause_midway = 1'b0;
                wait_drained();
            end
        end
        wait_drained();
    endtask

    // receiver holds off for a long stretch while short strings keep coming,
    // so the block backs up to its input
    task automatic fill_while_blocked();
        @(posedge clk);
        rx_stall_left = 500;
        repeat (60)
        begin
            if ($urandom_range(1) == 0)
                push_text("7", 1'b0);
            else
                push_text("-1", 1'b0);
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        char_ch.valid         = 1'b0;
        char_ch.char_byte     = '0;
        char_ch.has_char      = 1'b0;
        char_ch.end_of_string = 1'b0;
        res_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        mode_signed = 1'b0;
        mode_wide   = 1'b1;
        clear_parse();

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first stage: sender idles a little, receiver a lot
        set_idling(19, 75);

        // directed strings in the reset modes (unsigned, 64-bit)
        push_text("0", 1'b0);
        push_text(" \t+7", 1'b0);           // whitespace then plus sign
        push_text("-5", 1'b0);              // minus refused when unsigned
        push_text("", 1'b1);                // empty string
        push_text("\r\n", 1'b0);            // only whitespace
        push_text("+", 1'b0);               // only a sign
        push_text("+-1", 1'b0);             // second sign stops the parse
        push_text("9x9", 1'b0);             // trailing text ignored
        push_item(8'hFF, 1'b0, 1'b0);       // no char and not last does nothing
        push_text("3", 1'b0);
        push_item(8'h00, 1'b1, 1'b1);       // lowest byte as the whole string
        push_item(8'hFF, 1'b1, 1'b1);       // highest byte as the whole string
        push_text("12", 1'b1);              // string closed by a no-char marker
        wait_drained();

        run_phase(1'b1, 1'b1, 200, 1'b0);
        run_phase(1'b0, 1'b1, 200, 1'b0);

        // second stage: the other way round
        set_idling(75, 19);
        run_phase(1'b0, 1'b0, 200, 1'b0);
        run_phase(1'b1, 1'b0, 200, 1'b1);

        // last stage: no idling at all
        set_idling(0, 0);
        fill_while_blocked();
        run_phase(1'b1, 1'b1, 200, 1'b0);
        run_phase(1'b0, 1'b1, 200, 1'b0);
        run_phase(1'b1, 1'b0, 200, 1'b0);
        run_phase(1'b0, 1'b0, 200, 1'b0);

        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #4_800_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
rtl/dtoi_pkg.sv
rtl/dtoi_char_if.sv
rtl/dtoi_result_if.sv
rtl/dtoi_cfg_if.sv
rtl/dtoi_parse.sv
rtl/dtoi_result.sv
rtl/decimal_text_to_integer_top.sv
sim/testbench.sv
